FILE: design/node_address_table_and_command_framer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the node address table and command framer
// Shared property shapes for the sequencer and the datapath.
// ----------------------------------------------------------------------------
`ifndef NODE_ADDRESS_TABLE_AND_COMMAND_FRAMER_MACROS_SVH
`define NODE_ADDRESS_TABLE_AND_COMMAND_FRAMER_MACROS_SVH

// Same-cycle implication
`define NATCF_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define NATCF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/natcf_pkg.sv
// ----------------------------------------------------------------------------
// natcf_pkg
// Types, constants and the microcode table of the address table and framer.
// ----------------------------------------------------------------------------
package natcf_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam int FRAME_BYTES     = 50;
   localparam int PC_W            = 6;

   // Frame constants
   localparam logic [7:0] LEARN_TYPE  = 8'h90;
   localparam logic [7:0] DELIM       = 8'h7E;
   localparam logic [7:0] LEN_HI      = 8'h00;
   localparam logic [7:0] LEN_LO      = 8'h2E;
   localparam logic [7:0] TX_REQ      = 8'h10;
   localparam logic [7:0] FRAME_ID    = 8'h01;
   localparam logic [7:0] NET_HI      = 8'hFF;
   localparam logic [7:0] NET_LO      = 8'hFE;
   localparam logic [7:0] ENDPT       = 8'h30;
   localparam logic [7:0] CLUSTER     = 8'h8A;
   localparam logic [7:0] ZERO_BYTE   = 8'h00;

   // Program layout
   localparam logic [PC_W-1:0] STEP_IDLE   = 6'd0;
   localparam logic [PC_W-1:0] STEP_LCHECK = 6'd1;
   localparam logic [PC_W-1:0] STEP_SEARCH = 6'd2;
   localparam logic [PC_W-1:0] STEP_STORE  = 6'd3;
   localparam logic [PC_W-1:0] STEP_REPORT = 6'd4;
   localparam logic [PC_W-1:0] STEP_CREAD  = 6'd5;
   localparam logic [PC_W-1:0] STEP_CLOAD  = 6'd6;
   localparam logic [PC_W-1:0] STEP_FRAME  = 6'd7;
   localparam logic [PC_W-1:0] STEP_LAST   = 6'd56;

   typedef enum logic [2:0] {
      J_NEXT,
      J_GOTO,
      J_DISPATCH,
      J_LCHECK,
      J_SEARCH
   } jump_type;

   typedef enum logic [2:0] {
      SRC_ZERO,
      SRC_CONST,
      SRC_ADDR,
      SRC_CHAN,
      SRC_LEVEL,
      SRC_SUM
   } src_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SRCH_START,
      OP_SRCH_STEP,
      OP_STORE,
      OP_CMD_READ,
      OP_CMD_LOAD
   } op_type;

   typedef struct packed {
      jump_type        cond;
      logic [PC_W-1:0] target;
      op_type          op;
      src_type         src;
      logic [7:0]      value;
      logic            emit;
      logic            kind;
      logic            last;
      logic            sum_en;
   } ucode_type;

   typedef struct packed {
      ucode_type uw;
      logic      adv;
      logic      accept;
   } ctl_type;

   typedef struct packed {
      logic lrn_ok;
      logic count_zero;
      logic match;
      logic search_done;
      logic slot_free;
   } status_type;

   // One frame byte step, by offset in the frame
   function automatic ucode_type frame_word(input logic [PC_W-1:0] ofs);
      ucode_type       w;
      logic [PC_W-1:0] rel;
      w        = '0;
      rel      = '0;
      w.cond   = J_NEXT;
      w.target = STEP_IDLE;
      w.op     = OP_NONE;
      w.src    = SRC_CONST;
      w.emit   = 1'b1;
      w.kind   = 1'b1;
      w.sum_en = (ofs >= 6'd3) && (ofs <= 6'd48);
      priority if (ofs == 6'd0) w.value = DELIM;
      else if (ofs == 6'd1) w.value = LEN_HI;
      else if (ofs == 6'd2) w.value = LEN_LO;
      else if (ofs == 6'd3) w.value = TX_REQ;
      else if (ofs == 6'd4) w.value = FRAME_ID;
      else if (ofs <= 6'd12) begin
         rel     = ofs - 6'd5;
         w.src   = SRC_ADDR;
         w.value = {5'd0, rel[2:0]};
      end
      else if (ofs == 6'd13) w.value = NET_HI;
      else if (ofs == 6'd14) w.value = NET_LO;
      else if (ofs == 6'd17) w.value = ENDPT;
      else if (ofs >= 6'd26 && ofs <= 6'd33) begin
         rel     = ofs - 6'd26;
         w.src   = SRC_ADDR;
         w.value = {5'd0, rel[2:0]};
      end
      else if (ofs == 6'd34) w.value = ENDPT;
      else if (ofs == 6'd35) w.value = CLUSTER;
      else if (ofs >= 6'd36 && ofs <= 6'd43) begin
         rel     = ofs - 6'd36;
         w.src   = SRC_ADDR;
         w.value = {5'd0, rel[2:0]};
      end
      else if (ofs == 6'd44) w.src = SRC_CHAN;
      else if (ofs == 6'd45) w.src = SRC_LEVEL;
      else if (ofs == 6'd49) begin
         w.src  = SRC_SUM;
         w.last = 1'b1;
         w.cond = J_GOTO;
      end
      else w.value = ZERO_BYTE;
      return w;
   endfunction

   // Control store
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w        = '0;
      w.cond   = J_NEXT;
      w.target = STEP_IDLE;
      w.op     = OP_NONE;
      w.src    = SRC_ZERO;
      priority if (pc == STEP_IDLE) w.cond = J_DISPATCH;
      else if (pc == STEP_LCHECK) begin
         w.cond = J_LCHECK;
         w.op   = OP_SRCH_START;
      end
      else if (pc == STEP_SEARCH) begin
         w.cond = J_SEARCH;
         w.op   = OP_SRCH_STEP;
      end
      else if (pc == STEP_STORE) w.op = OP_STORE;
      else if (pc == STEP_REPORT) begin
         w.cond = J_GOTO;
         w.emit = 1'b1;
         w.last = 1'b1;
      end
      else if (pc == STEP_CREAD) w.op = OP_CMD_READ;
      else if (pc == STEP_CLOAD) w.op = OP_CMD_LOAD;
      else if (pc <= STEP_LAST) w = frame_word(pc - STEP_FRAME);
      else w.cond = J_GOTO;
      return w;
   endfunction

endpackage

FILE: design/natcf_seq.sv
// ----------------------------------------------------------------------------
// natcf_seq
// Step counter and control store; picks the next step from datapath status.
// ----------------------------------------------------------------------------
module natcf_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_func,
   output logic                  req_ready,
   input  natcf_pkg::status_type status,
   output natcf_pkg::ctl_type    ctl
);
   import natcf_pkg::*;
   `include "node_address_table_and_command_framer_macros.svh"

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   ucode_type       uw;
   logic            adv;
   logic            accept;

   assign uw        = ucode_rom(pc_ff);
   // hold an emitting step while the result register is occupied and not being taken
   assign adv       = !(uw.emit && !status.slot_free);
   assign req_ready = (uw.cond == J_DISPATCH);
   assign accept    = req_valid && req_ready;
   assign ctl       = '{uw: uw, adv: adv, accept: accept};

   always_comb begin
      pc_in = pc_ff;
      unique case (uw.cond)
         J_NEXT: begin
            if (adv) pc_in = pc_ff + PC_W'(1);
         end
         J_GOTO: begin
            if (adv) pc_in = uw.target;
         end
         J_DISPATCH: begin
            if (req_valid) pc_in = req_func ? STEP_CREAD : STEP_LCHECK;
         end
         J_LCHECK: begin
            priority if (!status.lrn_ok) pc_in = STEP_REPORT;
            else if (status.count_zero) pc_in = STEP_STORE;
            else pc_in = pc_ff + PC_W'(1);
         end
         J_SEARCH: begin
            priority if (status.match) pc_in = STEP_REPORT;
            else if (status.search_done) pc_in = STEP_STORE;
            else pc_in = pc_ff;
         end
         default: pc_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `NATCF_ASSERT_NXT(a_dispatch, clock, reset, accept,
      pc_ff == STEP_LCHECK || pc_ff == STEP_CREAD, "accept did not dispatch")
   `NATCF_ASSERT(a_pc_range, clock, reset, 1'b1, pc_ff <= STEP_LAST,
      "step counter out of program")
   `NATCF_ASSERT_NXT(a_last_idle, clock, reset, uw.emit && uw.last && adv,
      pc_ff == STEP_IDLE, "final result did not return to idle")

endmodule

FILE: design/natcf_dp.sv
// ----------------------------------------------------------------------------
// natcf_dp
// Address memory, search counter, frame byte select, checksum, result register.
// ----------------------------------------------------------------------------
module natcf_dp #(
   parameter int TABLE_DEPTH = natcf_pkg::TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  natcf_pkg::ctl_type    ctl,
   output natcf_pkg::status_type status,
   input  logic [7:0]            req_frame_type,
   input  logic [63:0]           req_source_address,
   input  logic [4:0]            req_entry_index,
   input  logic [7:0]            req_channel,
   input  logic [7:0]            req_level,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_kind,
   output logic [7:0]            rsp_tx_byte,
   output logic                  rsp_last,
   output logic                  rsp_added,
   output logic [5:0]            rsp_entry_count
);
   import natcf_pkg::*;
   `include "node_address_table_and_command_framer_macros.svh"

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [63:0]      mem [TABLE_DEPTH];
   logic [63:0]      rdata_ff;
   logic [IDX_W-1:0] rd_addr;

   logic [7:0]       type_ff;
   logic [4:0]       idx_ff;
   logic [7:0]       chan_ff;
   logic [7:0]       lvl_ff;
   logic [63:0]      addr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] sidx_ff;
   logic             added_ff;
   logic [7:0]       sum_ff;

   logic             rsp_valid_ff;
   logic             rsp_kind_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;
   logic             rsp_added_ff;
   logic [5:0]       rsp_count_ff;

   logic [8:0]       idx9;
   logic [8:0]       cnt9;
   logic [7:0][7:0]  addr_bytes;
   logic [7:0]       sel_byte;
   logic             emit_go;
   ucode_type        uw;

   assign uw         = ctl.uw;
   assign idx9       = {4'd0, idx_ff};
   assign cnt9       = 9'(count_ff);
   assign addr_bytes = addr_ff;
   assign emit_go    = uw.emit && ctl.adv;

   assign status.lrn_ok      = (type_ff == LEARN_TYPE) && (count_ff < CNT_W'(TABLE_DEPTH));
   assign status.count_zero  = (count_ff == '0);
   assign status.match       = (rdata_ff == addr_ff);
   assign status.search_done = (sidx_ff == count_ff);
   assign status.slot_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (uw.op)
         OP_CMD_READ:   rd_addr = idx9[IDX_W-1:0];
         OP_SRCH_START: rd_addr = '0;
         default:       rd_addr = sidx_ff[IDX_W-1:0];
      endcase
   end

   always_comb begin
      unique case (uw.src)
         SRC_CONST: sel_byte = uw.value;
         SRC_ADDR:  sel_byte = addr_bytes[3'd7 - uw.value[2:0]];
         SRC_CHAN:  sel_byte = chan_ff;
         SRC_LEVEL: sel_byte = lvl_ff;
         SRC_SUM:   sel_byte = ~sum_ff;
         default:   sel_byte = ZERO_BYTE;
      endcase
   end

   // address memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (uw.op == OP_STORE && ctl.adv) begin
         mem[count_ff[IDX_W-1:0]] <= addr_ff;
      end
   end

   // transaction fields and working registers
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         type_ff <= req_frame_type;
         idx_ff  <= req_entry_index;
         chan_ff <= req_channel;
         lvl_ff  <= req_level;
         addr_ff <= req_source_address;
      end else if (uw.op == OP_CMD_LOAD && ctl.adv) begin
         // entries at or past the fill count read as zero
         addr_ff <= (idx9 < cnt9) ? rdata_ff : 64'd0;
      end
      if (uw.op == OP_SRCH_START) begin
         sidx_ff <= CNT_W'(1);
      end else if (uw.op == OP_SRCH_STEP) begin
         sidx_ff <= sidx_ff + CNT_W'(1);
      end
      if (uw.op == OP_CMD_READ) begin
         sum_ff <= '0;
      end else if (emit_go && uw.sum_en) begin
         sum_ff <= sum_ff + sel_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         added_ff <= 1'b0;
      end else begin
         if (ctl.accept) begin
            added_ff <= 1'b0;
         end else if (uw.op == OP_STORE && ctl.adv) begin
            added_ff <= 1'b1;
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_go) begin
         rsp_kind_ff  <= uw.kind;
         rsp_byte_ff  <= sel_byte;
         rsp_last_ff  <= uw.last;
         rsp_added_ff <= uw.kind ? 1'b0 : added_ff;
         rsp_count_ff <= cnt9[5:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_tx_byte     = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_added       = rsp_added_ff;
   assign rsp_entry_count = rsp_count_ff;

   `NATCF_ASSERT(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH),
      "fill count beyond table depth")
   `NATCF_ASSERT(a_store_room, clock, reset, uw.op == OP_STORE && ctl.adv,
      count_ff < CNT_W'(TABLE_DEPTH), "store into a full table")
   `NATCF_ASSERT_NXT(a_unlearned_zero, clock, reset,
      uw.op == OP_CMD_LOAD && ctl.adv && idx9 >= cnt9,
      addr_ff == 64'd0, "unlearned entry did not read as zero")

endmodule

FILE: design/node_address_table_and_command_framer.sv
// ----------------------------------------------------------------------------
// node_address_table_and_command_framer
// Learns node addresses from received frames and builds 50-byte command frames.
// ----------------------------------------------------------------------------
//  channel   ports                       direction
//  request   req_valid / req_ready       in   func, type, address, index, chan, level
//  response  rsp_valid / rsp_ready       out  kind, byte, last, added, entry count
//
//  Learn transaction: compares stored entries in turn (at most the fill count), then
//  stores the address when none matches; one memory read per cycle on the single read port.
//  Command transaction: one frame byte per cycle after the entry read, while the result register is free.
//  Reset empties the table by clearing its fill count; no clearing pass.
//  A byte step holds while the result register is full and not taken.
// ----------------------------------------------------------------------------
module node_address_table_and_command_framer #(
   parameter int TABLE_DEPTH = natcf_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_frame_type,
   input  logic [63:0] req_source_address,
   input  logic [4:0]  req_entry_index,
   input  logic [7:0]  req_channel,
   input  logic [7:0]  req_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_added,
   output logic [5:0]  rsp_entry_count
);
   import natcf_pkg::*;

   ctl_type    ctl;
   status_type status;

   natcf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .status    (status),
      .ctl       (ctl)
   );

   natcf_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .status             (status),
      .req_frame_type     (req_frame_type),
      .req_source_address (req_source_address),
      .req_entry_index    (req_entry_index),
      .req_channel        (req_channel),
      .req_level          (req_level),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_last           (rsp_last),
      .rsp_added          (rsp_added),
      .rsp_entry_count    (rsp_entry_count)
   );

endmodule
